// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  `ASSERT_PROP(lbl, clk, rst, (ante) |-> (cons), msg)

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  `ASSERT_PROP(lbl, clk, rst, (ante) |=> (cons), msg)

`endif

// ----- hdl/spq_pkg.sv -----
// Shared types and constants of the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int VALUE_W  = 32;
  localparam int IN_PRI_W = 8;
  localparam int PRI_EXT_W = 16;
  localparam int IN_TDATA_W = VALUE_W + IN_PRI_W;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_NOMATCH = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMPACT,
    S_REPORT
  } state_t;

  typedef struct packed {
    logic ins;
    logic mark;
    logic step;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/spq_cell.sv -----
// One queue cell: holds an entry and trades it with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5,
  parameter int PRI_W = 8
) (
  input  wire                    clk,
  input  spq_pkg::cell_ctl_t     ctl,
  input  wire [CNT_W-1:0]        count,
  input  wire [31:0]             new_value,
  input  wire [PRI_W-1:0]        new_pri,
  input  wire                    prev_occ,
  input  wire                    prev_gt,
  input  wire                    prev_keep,
  input  wire [31:0]             prev_value,
  input  wire [PRI_W-1:0]        prev_pri,
  input  wire                    nxt_keep,
  input  wire                    nxt_tally,
  input  wire [31:0]             nxt_value,
  input  wire [PRI_W-1:0]        nxt_pri,
  output logic                   occ,
  output logic                   gt,
  output logic                   keep,
  output logic                   tally,
  output logic                   move,
  output logic [31:0]            value,
  output logic [PRI_W-1:0]       pri
);
  import spq_pkg::*;

  logic take_next;
  logic put_new;
  logic match;

  assign occ       = count > CNT_W'(IDX);
  assign gt        = occ && (pri > new_pri);
  assign match     = value == new_value;
  assign take_next = nxt_keep && !keep;
  assign move      = keep && !prev_keep;
  assign put_new   = !prev_gt && (gt || !occ) && prev_occ;

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (prev_gt) begin
        value <= prev_value;
        pri   <= prev_pri;
      end else if (put_new) begin
        value <= new_value;
        pri   <= new_pri;
      end
    end
    if (ctl.mark) begin
      keep  <= occ && !match;
      tally <= occ && match;
    end
    if (ctl.step) begin
      tally <= nxt_tally;
      if (take_next) begin
        value <= nxt_value;
        pri   <= nxt_pri;
        keep  <= 1'b1;
      end else if (move) begin
        keep  <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/spq_ctrl.sv -----
// Command sequencer: entry count, removal tally and result status.
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl #(
  parameter  int DEPTH = 16,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  input  wire                  in_cmd,
  input  wire                  hold_valid,
  input  wire                  tally0,
  input  wire                  any_move,
  output logic                 tready,
  output spq_pkg::cell_ctl_t   ctl,
  output logic [CNT_W-1:0]     count,
  output logic [CNT_W-1:0]     removed,
  output spq_pkg::status_t     status,
  output logic                 push
);
  import spq_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] step_cnt;
  logic [CNT_W-1:0] removed_sum;
  logic             accept;
  logic             full;
  logic             last_step;
  logic             done;

  assign full        = count == CNT_W'(DEPTH);
  assign last_step   = step_cnt == CNT_W'(DEPTH - 1);
  assign done        = last_step && !any_move;
  assign removed_sum = removed + CNT_W'(tally0);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && !hold_valid) begin
          state_next = (in_cmd == CMD_DELETE) ? S_COMPACT : S_REPORT;
        end
      end
      S_COMPACT: begin
        if (done) begin
          state_next = S_REPORT;
        end
      end
      S_REPORT: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    tready   = (state == S_IDLE) && !hold_valid;
    accept   = in_valid && tready;
    ctl.ins  = accept && (in_cmd == CMD_INSERT) && !full;
    ctl.mark = accept && (in_cmd == CMD_DELETE);
    ctl.step = state == S_COMPACT;
    push     = state == S_REPORT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (ctl.ins) begin
        count <= count + CNT_W'(1);
      end
      if (ctl.step && done) begin
        count <= count - removed_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      removed  <= '0;
      step_cnt <= '0;
      if (in_cmd == CMD_INSERT) begin
        status <= full ? STAT_FULL : STAT_DONE;
      end
    end
    if (ctl.step) begin
      removed <= removed_sum;
      if (!last_step) begin
        step_cnt <= step_cnt + CNT_W'(1);
      end
      if (done) begin
        status <= (removed_sum == '0) ? STAT_NOMATCH : STAT_DONE;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sorted_priority_queue_top.sv -----
// Top level of the sorted priority queue: cell chain, sequencer and output buffer.
//
// Holds up to DEPTH entries of a 32-bit value and a PRIORITY_BITS priority in a
// chain of cells kept in ascending priority order, ties in arrival order. One
// command is in work at a time. On an insert every cell compares against the new
// priority and the cells holding a greater one shift up by one in the same cycle,
// then the result is reported. A delete first marks all cells whose value matches,
// then the removal tally walks down the chain one cell per cycle while gaps close
// by one cell per cycle in the same window until the last step sees no move, then
// the result is reported. A two-entry output buffer lets the next command enter
// while one result waits on the master side. No clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue_top #(
  parameter  int DEPTH         = 16,
  parameter  int PRIORITY_BITS = 8,
  localparam int CNT_W         = $clog2(DEPTH + 1),
  localparam int OUT_BITS      = 2 + 2 * CNT_W + 1 + spq_pkg::VALUE_W + spq_pkg::IN_PRI_W,
  localparam int OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // item_value [31:0], item_priority [39:32]
  input  wire [spq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // cmd [0]
  input  wire [0:0]                         s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // status, removed_count, entry_count, head_valid, head_value, head_priority, zero fill
  output logic [OUT_TDATA_W-1:0]            m_axis_tdata
);
  import spq_pkg::*;

  localparam int PRI_W = PRIORITY_BITS;

  cell_ctl_t               ctl;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        removed;
  status_t                 status;
  logic                    push;
  logic                    hold_valid;
  logic [OUT_TDATA_W-1:0]  hold_data;
  logic [OUT_TDATA_W-1:0]  res_data;
  logic                    take;

  logic [31:0]             new_value;
  logic [PRI_EXT_W-1:0]    in_pri_ext;
  logic [PRI_W-1:0]        new_pri;
  logic [PRI_EXT_W-1:0]    head_pri_ext;
  logic                    head_valid;
  logic [31:0]             head_value;
  logic [IN_PRI_W-1:0]     head_pri;

  logic [DEPTH-1:0]        occ_w;
  logic [DEPTH-1:0]        gt_w;
  logic [DEPTH-1:0]        keep_w;
  logic [DEPTH-1:0]        tally_w;
  logic [DEPTH-1:0]        move_w;
  logic [31:0]             value_w [DEPTH];
  logic [PRI_W-1:0]        pri_w   [DEPTH];

  logic [DEPTH-1:0]        prev_occ;
  logic [DEPTH-1:0]        prev_gt;
  logic [DEPTH-1:0]        prev_keep;
  logic [31:0]             prev_value [DEPTH];
  logic [PRI_W-1:0]        prev_pri   [DEPTH];
  logic [DEPTH-1:0]        nxt_keep;
  logic [DEPTH-1:0]        nxt_tally;
  logic [31:0]             nxt_value [DEPTH];
  logic [PRI_W-1:0]        nxt_pri   [DEPTH];

  assign new_value  = s_axis_tdata[31:0];
  assign in_pri_ext = PRI_EXT_W'(s_axis_tdata[IN_TDATA_W-1:VALUE_W]);
  assign new_pri    = in_pri_ext[PRI_W-1:0];

  spq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_cmd     (s_axis_tuser[0]),
    .hold_valid (hold_valid),
    .tally0     (tally_w[0]),
    .any_move   (|move_w),
    .tready     (s_axis_tready),
    .ctl        (ctl),
    .count      (count),
    .removed    (removed),
    .status     (status),
    .push       (push)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_occ[i]   = 1'b1;
      assign prev_gt[i]    = 1'b0;
      assign prev_keep[i]  = 1'b1;
      assign prev_value[i] = '0;
      assign prev_pri[i]   = '0;
    end else begin : g_mid
      assign prev_occ[i]   = occ_w[i-1];
      assign prev_gt[i]    = gt_w[i-1];
      assign prev_keep[i]  = keep_w[i-1];
      assign prev_value[i] = value_w[i-1];
      assign prev_pri[i]   = pri_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign nxt_keep[i]  = 1'b0;
      assign nxt_tally[i] = 1'b0;
      assign nxt_value[i] = '0;
      assign nxt_pri[i]   = '0;
    end else begin : g_inner
      assign nxt_keep[i]  = keep_w[i+1];
      assign nxt_tally[i] = tally_w[i+1];
      assign nxt_value[i] = value_w[i+1];
      assign nxt_pri[i]   = pri_w[i+1];
    end

    spq_cell #(
      .IDX   (i),
      .CNT_W (CNT_W),
      .PRI_W (PRI_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count),
      .new_value  (new_value),
      .new_pri    (new_pri),
      .prev_occ   (prev_occ[i]),
      .prev_gt    (prev_gt[i]),
      .prev_keep  (prev_keep[i]),
      .prev_value (prev_value[i]),
      .prev_pri   (prev_pri[i]),
      .nxt_keep   (nxt_keep[i]),
      .nxt_tally  (nxt_tally[i]),
      .nxt_value  (nxt_value[i]),
      .nxt_pri    (nxt_pri[i]),
      .occ        (occ_w[i]),
      .gt         (gt_w[i]),
      .keep       (keep_w[i]),
      .tally      (tally_w[i]),
      .move       (move_w[i]),
      .value      (value_w[i]),
      .pri        (pri_w[i])
    );
  end

  assign head_valid   = count != '0;
  assign head_pri_ext = head_valid ? PRI_EXT_W'(pri_w[0]) : '0;
  assign head_value   = head_valid ? value_w[0] : '0;
  assign head_pri     = head_pri_ext[IN_PRI_W-1:0];
  assign res_data     = OUT_TDATA_W'({head_pri, head_value, head_valid, count, removed,
                                      status});

  assign take = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      hold_valid    <= 1'b0;
    end else if (!m_axis_tvalid || take) begin
      if (hold_valid) begin
        m_axis_tvalid <= 1'b1;
        hold_valid    <= push;
      end else begin
        m_axis_tvalid <= push;
      end
    end else if (push) begin
      hold_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_axis_tvalid || take) begin
      if (hold_valid) begin
        m_axis_tdata <= hold_data;
        hold_data    <= res_data;
      end else begin
        m_axis_tdata <= res_data;
      end
    end else if (push) begin
      hold_data <= res_data;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/spq_checker.sv -----
// Port-level checker for the sorted priority queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module spq_checker #(
  parameter  int DEPTH       = 16,
  localparam int CNT_W       = $clog2(DEPTH + 1),
  localparam int OUT_BITS    = 2 + 2 * CNT_W + 1 + spq_pkg::VALUE_W + spq_pkg::IN_PRI_W,
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input wire                            clk,
  input wire                            rst,
  input wire                            s_axis_tvalid,
  input wire                            s_axis_tready,
  input wire [spq_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input wire [0:0]                      s_axis_tuser,
  input wire                            m_axis_tvalid,
  input wire                            m_axis_tready,
  input wire [OUT_TDATA_W-1:0]          m_axis_tdata
);
  import spq_pkg::*;

  localparam int RM_LO = 2;
  localparam int EC_LO = RM_LO + CNT_W;
  localparam int HV_LO = EC_LO + CNT_W;
  localparam int HD_LO = HV_LO + 1;
  localparam int HP_LO = HD_LO + VALUE_W;

  logic [1:0]          o_status;
  logic [CNT_W-1:0]    o_removed;
  logic [CNT_W-1:0]    o_count;
  logic                o_head_valid;
  logic [31:0]         o_head_value;
  logic [IN_PRI_W-1:0] o_head_pri;
  logic                in_xfer;

  assign o_status     = m_axis_tdata[1:0];
  assign o_removed    = m_axis_tdata[EC_LO-1:RM_LO];
  assign o_count      = m_axis_tdata[HV_LO-1:EC_LO];
  assign o_head_valid = m_axis_tdata[HV_LO];
  assign o_head_value = m_axis_tdata[HP_LO-1:HD_LO];
  assign o_head_pri   = m_axis_tdata[HP_LO+IN_PRI_W-1:HP_LO];
  assign in_xfer      = s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] | !s_axis_tuser[0])
                        && (s_axis_tdata == s_axis_tdata);

  `ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  `ASSERT_NEXT(a_one_in_work, clk, rst, in_xfer, !s_axis_tready, "second command taken while one is in work")
  `ASSERT_IMPLIES(a_head_flag, clk, rst, m_axis_tvalid, o_head_valid == (o_count != '0) && (o_head_valid || (o_head_value == '0 && o_head_pri == '0)), "head fields disagree with entry count")
  `ASSERT_IMPLIES(a_count_range, clk, rst, m_axis_tvalid, o_count <= CNT_W'(DEPTH) && o_removed <= CNT_W'(DEPTH), "count beyond depth")
  `ASSERT_IMPLIES(a_status_removed, clk, rst, m_axis_tvalid, (o_status != STAT_NOMATCH || o_removed == '0) && (o_status != STAT_FULL || o_removed == '0) && o_status != 2'd3, "status and removed count disagree")

endmodule

bind sorted_priority_queue_top spq_checker #(.DEPTH(DEPTH)) u_spq_checker (.*);

`default_nettype wire
